>>> rtl/dkn_pkg.sv
// Shared types and constants for the debounced key note event block.
// No dependencies; every module imports this package.
package dkn_pkg;

  localparam int RAW_BITS   = 12;
  localparam int KEY_W      = 4;
  localparam int NOTE_W     = 7;
  localparam int STAMP_W    = 32;
  localparam int DEB_W      = 10;
  localparam int SHIFT_W    = 6;
  localparam int NOTE_BASE  = 60;
  localparam int NOTE_MAX   = 127;
  localparam logic [DEB_W-1:0] DEB_RESET = 10'd20;
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = -6'sd24;
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 6'sd24;

  // command broadcast to every lane for one scan
  typedef struct packed {
    logic                      accept;
    logic                      release_all;
    logic                      scan;
    logic signed [SHIFT_W-1:0] shift;
    logic [DEB_W-1:0]          debounce_ms;
    logic [STAMP_W-1:0]        now_ms;
  } lane_cmd_t;

  // what one lane found for the current scan
  typedef struct packed {
    logic              rel;
    logic [NOTE_W-1:0] rel_note;
    logic              ev;
    logic              ev_on;
    logic [NOTE_W-1:0] ev_note;
  } lane_evt_t;

  function automatic logic [NOTE_W-1:0] note_clamp(input logic signed [8:0] n);
    logic [NOTE_W-1:0] r;
    if (n < 9'sd0) begin
      r = '0;
    end else if (n > 9'(NOTE_MAX)) begin
      r = NOTE_W'(NOTE_MAX);
    end else begin
      r = n[NOTE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/dkn_scan_if.sv
// Valid/ready channel carrying one keyboard scan.
// Depends on nothing.
interface dkn_scan_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [11:0] raw_keys;
  logic        enable;
  logic signed [5:0] transpose;

  modport source (output valid, now_ms, raw_keys, enable, transpose, input ready);
  modport sink   (input valid, now_ms, raw_keys, enable, transpose, output ready);
endinterface

>>> rtl/dkn_event_if.sv
// Valid/ready channel carrying one note-on or note-off event.
// Depends on nothing.
interface dkn_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_index;
  logic [6:0] note;
  logic       note_on;
  logic       last;

  modport source (output valid, key_index, note, note_on, last, input ready);
  modport sink   (input valid, key_index, note, note_on, last, output ready);
endinterface

>>> rtl/dkn_lane.sv
// One key lane: debounce state, held flag and sounding note of a single key.
// Depends on dkn_pkg.
module dkn_lane
  import dkn_pkg::*;
#(
  parameter int KEY_IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  lane_cmd_t cmd,
  input  logic      raw,
  output lane_evt_t evt
);

  localparam logic signed [8:0] KEY_OFS = 9'(NOTE_BASE + KEY_IDX);

  logic                last_raw;
  logic [STAMP_W-1:0]  change_stamp;
  logic                held;
  logic [NOTE_W-1:0]   sounding_note;

  logic                held_eff;
  logic [NOTE_W-1:0]   note_eff;
  logic                changed;
  logic                settled;
  logic [STAMP_W-1:0]  elapsed;
  logic [NOTE_W-1:0]   on_note;
  logic                held_next;
  logic [NOTE_W-1:0]   sounding_note_next;

  always_comb begin
    held_eff = held & ~cmd.release_all;
    note_eff = cmd.release_all ? '0 : sounding_note;
    changed  = raw != last_raw;
    elapsed  = cmd.now_ms - change_stamp;
    settled  = cmd.scan && !changed && (elapsed >= STAMP_W'(cmd.debounce_ms));
    on_note  = note_clamp(KEY_OFS + $signed({{3{cmd.shift[SHIFT_W-1]}}, cmd.shift}));

    evt.rel      = cmd.release_all & held;
    evt.rel_note = sounding_note;
    evt.ev       = 1'b0;
    evt.ev_on    = 1'b0;
    evt.ev_note  = '0;
    held_next          = held_eff;
    sounding_note_next = note_eff;
    if (settled && raw && !held_eff) begin
      evt.ev             = 1'b1;
      evt.ev_on          = 1'b1;
      evt.ev_note        = on_note;
      held_next          = 1'b1;
      sounding_note_next = on_note;
    end else if (settled && !raw && held_eff) begin
      evt.ev             = 1'b1;
      evt.ev_note        = note_eff;
      held_next          = 1'b0;
      sounding_note_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= 1'b0;
      change_stamp  <= '0;
      held          <= 1'b0;
      sounding_note <= '0;
    end else if (cmd.accept) begin
      held          <= held_next;
      sounding_note <= sounding_note_next;
      // restart the debounce window on a raw change
      if (cmd.scan && changed) begin
        last_raw     <= raw;
        change_stamp <= cmd.now_ms;
      end
    end
  end

endmodule

>>> rtl/dkn_merge.sv
// Merging stage: captures what all lanes found for a scan and drains the
// events in order (releases first, then scan events, each by key index).
// Depends on dkn_pkg and dkn_event_if.
module dkn_merge
  import dkn_pkg::*;
#(
  parameter int NUM_KEYS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  lane_evt_t   evt [NUM_KEYS],
  output logic        ready,
  dkn_event_if.source note_evt
);

  logic [NUM_KEYS-1:0] rel_mask;
  logic [NUM_KEYS-1:0] ev_mask;
  logic [NOTE_W-1:0]   rel_note [NUM_KEYS];
  logic [NOTE_W-1:0]   ev_note  [NUM_KEYS];
  logic [NUM_KEYS-1:0] ev_on;

  logic [NUM_KEYS-1:0] rel_mask_next;
  logic [NUM_KEYS-1:0] ev_mask_next;
  logic [KEY_W-1:0]    pick;
  logic                pick_rel;
  logic                any;
  logic                load;

  assign any   = (|rel_mask) | (|ev_mask);
  assign load  = !note_evt.valid || note_evt.ready;
  assign ready = !any && !note_evt.valid;

  // lowest pending key, releases ahead of scan events
  always_comb begin
    pick     = '0;
    pick_rel = |rel_mask;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pick_rel ? rel_mask[i] : ev_mask[i]) begin
        pick = KEY_W'(i);
      end
    end
    rel_mask_next = rel_mask;
    ev_mask_next  = ev_mask;
    if (pick_rel) begin
      rel_mask_next[pick] = 1'b0;
    end else begin
      ev_mask_next[pick] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_mask       <= '0;
      ev_mask        <= '0;
      note_evt.valid <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        rel_mask[i] <= evt[i].rel;
        ev_mask[i]  <= evt[i].ev;
      end
    end else if (load) begin
      note_evt.valid <= any;
      if (any) begin
        rel_mask <= rel_mask_next;
        ev_mask  <= ev_mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        rel_note[i] <= evt[i].rel_note;
        ev_note[i]  <= evt[i].ev_note;
        ev_on[i]    <= evt[i].ev_on;
      end
    end
    if (!accept && load && any) begin
      note_evt.key_index <= pick;
      note_evt.note      <= pick_rel ? rel_note[pick] : ev_note[pick];
      note_evt.note_on   <= pick_rel ? 1'b0 : ev_on[pick];
      note_evt.last      <= (rel_mask_next == '0) && (ev_mask_next == '0);
    end
  end

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!any && !note_evt.valid))
    else $error("scan taken while events pending");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (note_evt.valid && note_evt.ready && note_evt.last) |-> !any)
    else $error("events left after last transfer");

  a_not_last_pending: assert property (@(posedge clk) disable iff (rst)
    (note_evt.valid && !note_evt.last) |-> any)
    else $error("non-final event with nothing pending");

endmodule

>>> rtl/debounced_key_note_events.sv
// Top level of the debounced keyboard scanner: enable/transpose control,
// one lane per key and the merging stage.
// Depends on dkn_pkg, dkn_scan_if, dkn_event_if, dkn_lane and dkn_merge.
//
// Usage: each transfer on scan carries one keyboard scan (timestamp, raw key
// levels, enable, transpose). The block answers with zero to 2*NUM_KEYS note
// events on note_evt, releases of held keys first, then debounced key events
// in key order; last marks the final event of a scan.
// Flow: all lanes evaluate a scan in the cycle it is taken. A scan with no
// events leaves the input ready again in the next cycle; for a scan with E
// events the lane results are captured in the merge masks, then the first
// event is registered onto note_evt, and the next scan is taken in the cycle
// after the last event leaves. The merge stage drains one event per cycle
// while the receiver keeps up, and takes no new scan until all are drained.
// A stalled receiver holds the current event and the input stays not ready.
// Reset: disabled, transpose 0, all keys released, debounce_ms = 20.
// cfg_we/cfg_data write debounce_ms; write only while idle.
module debounced_key_note_events
  import dkn_pkg::*;
#(
  parameter int NUM_KEYS = 12
) (
  input  logic             clk,
  input  logic             rst,
  dkn_scan_if.sink         scan,
  dkn_event_if.source      note_evt,
  input  logic             cfg_we,
  input  logic [DEB_W-1:0] cfg_data
);

  logic                      active;
  logic signed [SHIFT_W-1:0] shift;
  logic [DEB_W-1:0]          debounce_ms;
  logic signed [SHIFT_W-1:0] req;
  logic                      accept;
  logic                      merge_ready;
  lane_cmd_t                 cmd;
  lane_evt_t                 evt [NUM_KEYS];

  assign accept     = scan.valid && merge_ready;
  assign scan.ready = merge_ready;

  always_comb begin
    if (scan.transpose < SHIFT_MIN) begin
      req = SHIFT_MIN;
    end else if (scan.transpose > SHIFT_MAX) begin
      req = SHIFT_MAX;
    end else begin
      req = scan.transpose;
    end
    cmd.accept      = accept;
    // enable falling, or a transpose change while enabled, kills held notes
    cmd.release_all = (active && !scan.enable) || (scan.enable && (req != shift));
    cmd.scan        = scan.enable;
    cmd.shift       = req;
    cmd.debounce_ms = debounce_ms;
    cmd.now_ms      = scan.now_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      shift       <= '0;
      debounce_ms <= DEB_RESET;
    end else begin
      if (cfg_we) begin
        debounce_ms <= cfg_data;
      end
      if (accept) begin
        active <= scan.enable;
        shift  <= req;
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic raw;
    if (k < RAW_BITS) begin : g_raw
      assign raw = scan.raw_keys[k];
    end else begin : g_none
      assign raw = 1'b0;
    end
    dkn_lane #(.KEY_IDX(k)) u_lane (
      .clk (clk),
      .rst (rst),
      .cmd (cmd),
      .raw (raw),
      .evt (evt[k])
    );
  end

  dkn_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .evt      (evt),
    .ready    (merge_ready),
    .note_evt (note_evt)
  );

endmodule

>>> test/debounced_key_note_events_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for debounced_key_note_events: a queue-fed scan driver, a
// stalling event receiver and a monitor that predicts note events per accepted scan.
// Depends on dkn_pkg, dkn_scan_if, dkn_event_if and the block itself.
module debounced_key_note_events_tb;
  import dkn_pkg::*;

  localparam int KEYS        = 12;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 4;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic [STAMP_W-1:0]        now_ms;
    logic [RAW_BITS-1:0]       raw_keys;
    logic                      enable;
    logic signed [SHIFT_W-1:0] transpose;
  } scan_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [NOTE_W-1:0] note;
    logic              note_on;
    logic              last;
  } note_event_t;

  typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_SLOW} rx_mode_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DEB_W-1:0] cfg_data;

  dkn_scan_if  scan_ch();
  dkn_event_if evt_ch();

  debounced_key_note_events #(.NUM_KEYS(KEYS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .scan     (scan_ch),
    .note_evt (evt_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // scans waiting to be offered and note events waiting to be seen
  scan_item_t  pending_scans[$];
  note_event_t expected_events[$];

  // shadow of the keyboard state
  logic [DEB_W-1:0]          debounce_reg;
  logic                      kb_active;
  logic signed [SHIFT_W-1:0] kb_shift;
  logic                      key_level[KEYS];
  logic [STAMP_W-1:0]        key_stamp[KEYS];
  logic                      key_held[KEYS];
  logic [NOTE_W-1:0]         key_note[KEYS];

  bit scan_fire;
  bit evt_fire;
  int idle_cycles;
  int mismatches;
  int hold_requests;
  int holds_served;

  // stimulus generator state
  logic [STAMP_W-1:0]  g_now;
  logic [RAW_BITS-1:0] g_keys;
  logic                g_en;
  int                  g_tr;

  function automatic scan_item_t scan_item(logic [31:0] now, logic [11:0] raw, logic en, int tr);
    scan_item_t s;
    s.now_ms    = now;
    s.raw_keys  = raw;
    s.enable    = en;
    s.transpose = SHIFT_W'(tr);
    return s;
  endfunction

  function automatic void release_held(ref note_event_t batch[$]);
    note_event_t e;
    for (int i = 0; i < KEYS; i++) begin
      if (key_held[i]) begin
        e.key_index = KEY_W'(i);
        e.note      = key_note[i];
        e.note_on   = 1'b0;
        e.last      = 1'b0;
        batch.push_back(e);
      end
      key_held[i] = 1'b0;
      key_note[i] = '0;
    end
  endfunction

  // work out the events of one scan and queue them
  function automatic void predict_scan(scan_item_t s);
    note_event_t batch[$];
    note_event_t e;
    int req;
    int n;
    logic lvl;
    logic [STAMP_W-1:0] elapsed;
    if (s.enable != kb_active) begin
      kb_active = s.enable;
      if (!s.enable) release_held(batch);
    end
    req = int'(s.transpose);
    if (req < int'(SHIFT_MIN)) req = int'(SHIFT_MIN);
    if (req > int'(SHIFT_MAX)) req = int'(SHIFT_MAX);
    if (req != int'(kb_shift)) begin
      if (kb_active) release_held(batch);
      kb_shift = SHIFT_W'(req);
    end
    if (kb_active) begin
      for (int i = 0; i < KEYS; i++) begin
        lvl = (i < RAW_BITS) ? s.raw_keys[i] : 1'b0;
        if (lvl != key_level[i]) begin
          key_level[i] = lvl;
          key_stamp[i] = s.now_ms;
          continue;
        end
        elapsed = s.now_ms - key_stamp[i];
        if (elapsed < STAMP_W'(debounce_reg)) continue;
        if (lvl && !key_held[i]) begin
          n = NOTE_BASE + i + int'(kb_shift);
          if (n < 0) n = 0;
          if (n > NOTE_MAX) n = NOTE_MAX;
          key_held[i] = 1'b1;
          key_note[i] = NOTE_W'(n);
          e.key_index = KEY_W'(i);
          e.note      = NOTE_W'(n);
          e.note_on   = 1'b1;
          e.last      = 1'b0;
          batch.push_back(e);
        end else if (!lvl && key_held[i]) begin
          key_held[i] = 1'b0;
          e.key_index = KEY_W'(i);
          e.note      = key_note[i];
          e.note_on   = 1'b0;
          e.last      = 1'b0;
          batch.push_back(e);
          key_note[i] = '0;
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
  endfunction

  function automatic void report_mismatch(string what, note_event_t want, note_event_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected key %0d note %0d on %b last %b, got key %0d note %0d on %b last %b",
               $realtime, what, want.key_index, want.note, want.note_on, want.last,
               got.key_index, got.note, got.note_on, got.last);
  endfunction

  // scan driver: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    scan_item_t item;
    logic nxt_valid;
    if (rst) begin
      scan_ch.valid <= 1'b0;
    end else if (!(scan_ch.valid && !scan_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_scans.size() > 0) begin
        item = pending_scans.pop_front();
        scan_ch.now_ms    <= item.now_ms;
        scan_ch.raw_keys  <= item.raw_keys;
        scan_ch.enable    <= item.enable;
        scan_ch.transpose <= item.transpose;
        nxt_valid = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      scan_ch.valid <= nxt_valid;
    end
  end

  // event receiver: stall pattern of its own plus requested long holds
  rx_mode_e rx_mode = RX_FREE;
  int mode_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      evt_ch.ready <= 1'b0;
    end else begin
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FREE:   rdy = 1'b1;
          RX_HALF:   rdy = ($urandom_range(0, 1) != 0);
          RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
          default:   rdy = ($urandom_range(0, 4) == 0);
        endcase
      end
      evt_ch.ready <= rdy;
    end
  end

  // monitor: predict on scan transfers, compare on event transfers
  always @(posedge clk) begin
    note_event_t got;
    note_event_t want;
    if (rst) begin
      scan_fire = 1'b0;
      evt_fire = 1'b0;
      idle_cycles = 0;
    end else begin
      scan_fire = scan_ch.valid && scan_ch.ready;
      evt_fire = evt_ch.valid && evt_ch.ready;
      if (scan_fire)
        predict_scan(scan_item(scan_ch.now_ms, scan_ch.raw_keys, scan_ch.enable,
                               int'(scan_ch.transpose)));
      if (evt_fire) begin
        got.key_index = evt_ch.key_index;
        got.note      = evt_ch.note;
        got.note_on   = evt_ch.note_on;
        got.last      = evt_ch.last;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) report_mismatch("event mismatch", want, got);
        end
      end
      if (scan_fire || evt_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_scans.size() != 0 || scan_ch.valid || expected_events.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_debounce(logic [DEB_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    debounce_reg = value;
  endtask

  // well-formed playing with random content, plus jumps and broken patterns
  task automatic queue_random_scans(int count);
    int r;
    @(posedge clk);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) g_now = $urandom();
      else if (r < 5) g_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else g_now = g_now + $urandom_range(0, debounce_reg / 2 + 3);
      r = $urandom_range(0, 99);
      if (r < 30) g_keys = g_keys ^ (12'd1 << $urandom_range(0, 11));
      else if (r < 38) g_keys = RAW_BITS'($urandom_range(0, 4095));
      if (g_en) begin
        if ($urandom_range(0, 99) < 4) g_en = 1'b0;
      end else if ($urandom_range(0, 99) < 35) begin
        g_en = 1'b1;
      end
      if ($urandom_range(0, 99) < 5) g_tr = $urandom_range(0, 63) - 32;
      pending_scans.push_back(scan_item(g_now, g_keys, g_en, g_tr));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    scan_ch.valid = 1'b0;
    scan_ch.now_ms = '0;
    scan_ch.raw_keys = '0;
    scan_ch.enable = 1'b0;
    scan_ch.transpose = '0;
    evt_ch.ready = 1'b0;
    debounce_reg = DEB_RESET;
    kb_active = 1'b0;
    kb_shift = '0;
    for (int i = 0; i < KEYS; i++) begin
      key_level[i] = 1'b0;
      key_stamp[i] = '0;
      key_held[i] = 1'b0;
      key_note[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed scans at the reset debounce time
    @(posedge clk);
    pending_scans.push_back(scan_item(32'd0, 12'h000, 1'b0, 0));
    pending_scans.push_back(scan_item(32'd5, 12'hFFF, 1'b0, 31));   // shift stored while off
    pending_scans.push_back(scan_item(32'd10, 12'hFFF, 1'b1, 31));  // enable rises, keys change
    pending_scans.push_back(scan_item(32'd20, 12'hFFF, 1'b1, 31));
    pending_scans.push_back(scan_item(32'd30, 12'hFFF, 1'b1, 31));  // all twelve note-ons
    pending_scans.push_back(scan_item(32'd31, 12'hFFF, 1'b1, -32)); // kill all, replay low
    pending_scans.push_back(scan_item(32'd40, 12'h0F0, 1'b1, -25)); // same clamped shift
    pending_scans.push_back(scan_item(32'd45, 12'h0F0, 1'b1, -25));
    pending_scans.push_back(scan_item(32'd60, 12'h0F0, 1'b1, -25));
    pending_scans.push_back(scan_item(32'd61, 12'h0F0, 1'b0, -25)); // disable releases rest
    pending_scans.push_back(scan_item(32'd62, 12'hFFF, 1'b0, 0));
    pending_scans.push_back(scan_item(32'd100, 12'hFFF, 1'b1, 0));
    pending_scans.push_back(scan_item(32'hFFFF_FFF0, 12'hFFF, 1'b1, 0));
    pending_scans.push_back(scan_item(32'hFFFF_FFF5, 12'h000, 1'b1, 0));
    pending_scans.push_back(scan_item(32'h0000_0005, 12'h000, 1'b1, 0)); // elapsed across wrap
    pending_scans.push_back(scan_item(32'h0000_0009, 12'h000, 1'b1, 0));
    pending_scans.push_back(scan_item(32'hFFFF_FFFF, 12'hA5A, 1'b1, 24));
    pending_scans.push_back(scan_item(32'hFFFF_FFFF, 12'hA5A, 1'b1, 24));
    pending_scans.push_back(scan_item(32'hFFFF_FFFF, 12'h5A5, 1'b0, 24));
    wait_drain();

    // zero debounce: a level holds after one unchanged scan
    write_debounce(10'd0);
    @(posedge clk);
    pending_scans.push_back(scan_item(32'd1000, 12'h001, 1'b1, 0));
    pending_scans.push_back(scan_item(32'd1000, 12'h001, 1'b1, 0));
    pending_scans.push_back(scan_item(32'd1001, 12'h800, 1'b1, 0));
    pending_scans.push_back(scan_item(32'd1001, 12'h800, 1'b1, 0));
    g_now = 32'd1001;
    g_keys = 12'h800;
    g_en = 1'b1;
    g_tr = 0;
    queue_random_scans(60);
    wait_drain();

    write_debounce(10'd1023);
    queue_random_scans(50);
    wait_drain();

    write_debounce(10'd1000);
    queue_random_scans(40);
    wait_drain();

    // short debounce with a long receiver hold so the block backs up
    write_debounce(10'd3);
    @(posedge clk);
    hold_requests++;
    queue_random_scans(80);
    wait_drain();

    write_debounce(DEB_W'($urandom_range(1, 40)));
    queue_random_scans(70);
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      mismatches++;
      $display("%0d expected events never arrived", expected_events.size());
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
